[sv/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// condition a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

[sv/jsu_pkg.sv]
package jsu_pkg;

  localparam int MaxResults = 5;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_FAIL  = 2'd2;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // characters of interest
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,
    PH_STR  = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [16:0] consumed;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]                   count;
    result_t [MaxResults-1:0]     entries;
  } burst_t;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] b;
  } utf8_t;

  // hex digit value, top bit flags a valid digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // code point to utf-8, one to three bytes, first byte in b[0]
  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t u;
    u.b = '0;
    if (cp <= 16'h007F) begin
      u.n    = 2'd1;
      u.b[0] = {1'b0, cp[6:0]};
    end else if (cp <= 16'h07FF) begin
      u.n    = 2'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else begin
      u.n    = 2'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

  function automatic result_t make_result(input logic [7:0] d, input logic [1:0] k,
                                          input logic [16:0] c);
    result_t r;
    r.data     = d;
    r.kind     = k;
    r.consumed = c;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

[sv/json_string_unescape_utf8.sv]
// path: an accepted byte passes the input register, then the result burst buffer, then the output register
// throughput: one byte per cycle while each byte gives at most one result and out_ready is high;
// a byte giving several results (up to five) holds the input side until its last result pops,
// set by the single result burst buffer draining one entry per cycle while out_ready allows
// reset: synchronous, clears all buffers and restarts decoding at leading whitespace
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [16:0] consumed,
  output logic        last
);

  logic       iv;
  logic [7:0] byte_q;
  logic       end_q;
  logic       load;
  logic       take;
  burst_t     burst;
  result_t    out_data;

  assign take     = iv && load;
  assign in_ready = !iv || load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
      end_q  <= buffer_end;
    end
  end

  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte_q (byte_q),
    .in_end_q  (end_q),
    .burst     (burst)
  );

  jsu_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .burst_in  (burst),
    .load      (load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_byte = out_data.data;
  assign kind     = out_data.kind;
  assign consumed = out_data.consumed;
  assign last     = out_data.last;

endmodule

[sv/jsu_decode.sv]
`include "assert_macros.svh"

module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte_q,
  input  logic       in_end_q,
  output burst_t     burst
);

  phase_t      phase, phase_next;
  logic [15:0] code_point, code_point_next;
  logic [2:0]  hex_seen, hex_seen_next;
  logic [16:0] byte_count, byte_count_next;

  logic [16:0] cnt_inc;
  logic [4:0]  hv;
  logic [15:0] cp_shift;
  utf8_t       pre;
  logic        pre_v;
  logic        mid_v;
  result_t     mid;
  logic        done;
  logic        use_str;
  logic        end_v;
  logic [2:0]  pos_mid, pos_end, count;
  logic [4:0][7:0] pre_pad;
  logic [MaxResults-1:0] last_vec;

  assign cnt_inc  = (byte_count == COUNT_MAX) ? byte_count : byte_count + 17'd1;
  assign hv       = hex_value(in_byte_q);
  assign cp_shift = {code_point[11:0], hv[3:0]};

  // per-byte decode
  always_comb begin
    phase_next      = phase;
    code_point_next = code_point;
    hex_seen_next   = hex_seen;
    pre             = utf8_encode(code_point);
    pre_v           = 1'b0;
    mid_v           = 1'b0;
    mid             = make_result(in_byte_q, KIND_DATA, 17'd0);
    done            = 1'b0;
    use_str         = 1'b0;
    case (phase)
      PH_SKIP: begin
        if (in_byte_q <= CH_SPACE) begin
          phase_next = PH_SKIP;
        end else if (in_byte_q == CH_QUOTE) begin
          phase_next = PH_STR;
        end else begin
          mid   = make_result(8'd0, KIND_FAIL, 17'd0);
          mid_v = 1'b1;
          done  = 1'b1;
        end
      end
      PH_STR: begin
        use_str = 1'b1;
      end
      PH_ESC: begin
        phase_next = PH_STR;
        mid_v      = 1'b1;
        case (in_byte_q)
          CH_BSLASH: mid.data = CH_BSLASH;
          CH_QUOTE:  mid.data = CH_QUOTE;
          CH_B:      mid.data = CH_BS;
          CH_F:      mid.data = CH_FF;
          CH_N:      mid.data = CH_LF;
          CH_R:      mid.data = CH_CR;
          CH_T:      mid.data = CH_TAB;
          CH_U: begin
            phase_next      = PH_HEX;
            code_point_next = 16'd0;
            hex_seen_next   = 3'd0;
            mid_v           = 1'b0;
          end
          default:   mid.data = CH_BSLASH;
        endcase
      end
      PH_HEX: begin
        if (hv[4]) begin
          if (hex_seen == 3'd3) begin
            pre             = utf8_encode(cp_shift);
            pre_v           = 1'b1;
            phase_next      = PH_STR;
            code_point_next = 16'd0;
            hex_seen_next   = 3'd0;
          end else begin
            code_point_next = cp_shift;
            hex_seen_next   = hex_seen + 3'd1;
          end
        end else if (hex_seen == 3'd0) begin
          mid   = make_result(8'd0, KIND_FAIL, 17'd0);
          mid_v = 1'b1;
          done  = 1'b1;
        end else begin
          // short escape: emit what was gathered, then treat byte as string body
          pre_v           = 1'b1;
          phase_next      = PH_STR;
          code_point_next = 16'd0;
          hex_seen_next   = 3'd0;
          use_str         = 1'b1;
        end
      end
      default: begin
        phase_next = PH_SKIP;
      end
    endcase

    // string body byte
    if (use_str) begin
      if (in_byte_q == CH_QUOTE) begin
        mid   = make_result(8'd0, KIND_CLOSE, cnt_inc);
        mid_v = 1'b1;
        done  = 1'b1;
      end else if (in_byte_q == CH_BSLASH) begin
        phase_next = PH_ESC;
      end else begin
        mid_v = 1'b1;
      end
    end
  end

  assign end_v   = in_end_q && !done;
  assign pos_mid = pre_v ? {1'b0, pre.n} : 3'd0;
  assign pos_end = pos_mid + {2'b00, mid_v};
  assign count   = pos_end + {2'b00, end_v};
  assign pre_pad = {16'h0000, pre.b};

  // lay out the results of this byte in order, empty when no request is taken
  always_comb begin
    burst.count = take ? count : 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      if (3'(i) < pos_mid) begin
        burst.entries[i] = make_result(pre_pad[i], KIND_DATA, 17'd0);
      end else if (3'(i) == pos_mid && mid_v) begin
        burst.entries[i] = mid;
      end else begin
        burst.entries[i] = make_result(8'd0, KIND_FAIL, 17'd0);
      end
      burst.entries[i].last = (count != 3'd0) && (3'(i) == count - 3'd1);
      last_vec[i] = burst.entries[i].last;
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SKIP;
      code_point <= 16'd0;
      hex_seen   <= 3'd0;
      byte_count <= 17'd0;
    end else if (take) begin
      if (done || in_end_q) begin
        phase      <= PH_SKIP;
        code_point <= 16'd0;
        hex_seen   <= 3'd0;
        byte_count <= 17'd0;
      end else begin
        phase      <= phase_next;
        code_point <= code_point_next;
        hex_seen   <= hex_seen_next;
        byte_count <= byte_count_next;
      end
    end
  end

  assign byte_count_next = cnt_inc;

  `ASSERT_IMPLIES(a_hex_seen_range, clk, rst, 1'b1, hex_seen <= 3'd3)
  `ASSERT_IMPLIES(a_one_last, clk, rst, take, $countones(last_vec) == ((count != 3'd0) ? 1 : 0))
  `ASSERT_NEXT(a_done_restart, clk, rst, take && (done || in_end_q), phase == PH_SKIP && byte_count == 17'd0)

endmodule

[sv/jsu_drain.sv]
`include "assert_macros.svh"

module jsu_drain
  import jsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  burst_t  burst_in,
  output logic    load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [2:0]               burst_n;
  result_t [MaxResults-1:0] entries;
  logic                     pop;

  assign pop  = (burst_n != 3'd0) && (!out_valid || out_ready);
  assign load = (burst_n == 3'd0) || (burst_n == 3'd1 && pop);

  // result burst buffer, head at entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_n <= 3'd0;
    end else if (load) begin
      burst_n <= burst_in.count;
    end else if (pop) begin
      burst_n <= burst_n - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= burst_in.entries;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= entries[0];
    end
  end

  `ASSERT_IMPLIES(a_burst_range, clk, rst, 1'b1, burst_n <= 3'(MaxResults))
  `ASSERT_NEXT(a_load_count, clk, rst, load, burst_n == $past(burst_in.count))
  `ASSERT_NEXT(a_pop_count, clk, rst, pop && !load, burst_n == $past(burst_n) - 3'd1)

endmodule
